FILE: sv/color_palette_slot_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// Colour palette slot allocator - assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef COLOR_PALETTE_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define COLOR_PALETTE_SLOT_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define CPSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define CPSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/cpsa_pkg.sv
// ----------------------------------------------------------------------------
// cpsa_pkg
// Types and constants shared by the colour palette slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cpsa_pkg;

  localparam int TEXTURE_SIDE = 32;
  localparam int SIDE_W       = $clog2(TEXTURE_SIDE);
  localparam int SLOT_W       = 2 * SIDE_W;
  localparam int SLOT_COUNT   = TEXTURE_SIDE * TEXTURE_SIDE;
  localparam int COUNT_W      = SLOT_W + 1;
  localparam int KEY_W        = 24;

  typedef struct packed {
    logic [7:0] color_red;
    logic [7:0] color_green;
    logic [7:0] color_blue;
  } cpsa_req_t;

  typedef struct packed {
    logic [4:0] slot_column;
    logic [4:0] slot_row;
    logic [5:0] u_numerator;
    logic [5:0] v_numerator;
    logic       newly_added;
    logic       table_full;
  } cpsa_rsp_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SEARCH
  } cpsa_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_key;
    logic scan;
    logic finish;
  } cpsa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic miss;
    logic rsp_busy;
  } cpsa_status_t;

endpackage

`default_nettype wire

FILE: sv/color_palette_slot_allocator_core.sv
// Colour palette slot allocator. Each request carries one 24-bit RGB colour;
// the block scans its table of colours already seen, oldest first, and
// answers with that colour's slot in a 32 x 32 palette texture (column, row
// and the numerators of u and v over 64, v flipped). A new colour takes the
// next free slot and the result sets newly_added, telling the user to write
// that texel. With all 1024 slots used, a new colour is not stored and the
// result sets table_full with all slot fields zero. One request is handled
// at a time: the search stops at the first matching entry, or reports a
// new colour once every stored colour has been read. The result is then
// registered, or held back while an earlier result is still unclaimed,
// and the sequencer returns to idle, ready for the next request, as it is
// registered. The search time is set by the single read port of the colour
// table, one entry per cycle.
// The result is registered and may wait for rsp_ready while the next
// request is accepted and searched. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// color_palette_slot_allocator_core
// Top level: sequencer plus table datapath with request/result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module color_palette_slot_allocator_core (
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  output logic               req_ready,
  input  cpsa_pkg::cpsa_req_t req,
  output logic               rsp_valid,
  input  wire                rsp_ready,
  output cpsa_pkg::cpsa_rsp_t rsp
);
  import cpsa_pkg::*;

  cpsa_cmd_t    cmd;
  cpsa_status_t status;

  // sequencer: idle -> search -> idle; stalls at the end of a search
  // only while an earlier result is still unclaimed
  cpsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // colour table (1024 x 24, one read and one write port), scan pointer,
  // compare stage, fill count and result register
  cpsa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

FILE: sv/cpsa_ctrl.sv
// ----------------------------------------------------------------------------
// cpsa_ctrl
// Sequencer: accepts a request, drives the table scan, hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsa_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   req_valid,
  output logic                  req_ready,
  input  cpsa_pkg::cpsa_status_t status,
  output cpsa_pkg::cpsa_cmd_t    cmd
);
  import cpsa_pkg::*;

  cpsa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_key = 1'b1;
          state_next   = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.hit || status.miss) begin
          // stall while the previous result is still held
          if (!status.rsp_busy) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.scan = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/cpsa_dp.sv
// ----------------------------------------------------------------------------
// cpsa_dp
// Colour table, scan pointer, compare stage, fill count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsa_dp (
  input  wire                   clk,
  input  wire                   rst,
  input  cpsa_pkg::cpsa_req_t    req,
  input  cpsa_pkg::cpsa_cmd_t    cmd,
  output cpsa_pkg::cpsa_status_t status,
  output logic                  rsp_valid,
  input  wire                   rsp_ready,
  output cpsa_pkg::cpsa_rsp_t    rsp
);
  import cpsa_pkg::*;

  logic [KEY_W-1:0]   mem [SLOT_COUNT];
  logic [KEY_W-1:0]   key;
  logic [KEY_W-1:0]   rd_data;
  logic [COUNT_W-1:0] scan_idx;
  logic [SLOT_W-1:0]  cmp_idx;
  logic               cmp_valid;
  logic [COUNT_W-1:0] fill_count;
  logic               rd_en;
  logic               wr_en;
  logic               full;
  logic [SLOT_W-1:0]  slot_sel;
  logic [SIDE_W-1:0]  col;
  logic [SIDE_W-1:0]  row;

  assign rd_en = cmd.scan && (scan_idx < fill_count);
  assign full  = (fill_count == COUNT_W'(SLOT_COUNT));

  assign status.hit      = cmp_valid && (rd_data == key);
  assign status.miss     = !cmp_valid && (scan_idx == fill_count);
  assign status.rsp_busy = rsp_valid && !rsp_ready;

  assign wr_en = cmd.finish && !status.hit && !full;

  // table
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[scan_idx[SLOT_W-1:0]];
    end
    if (wr_en) begin
      mem[fill_count[SLOT_W-1:0]] <= key;
    end
  end

  // scan pointer and compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.load_key) begin
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.scan) begin
      cmp_valid <= rd_en;
      if (rd_en) begin
        scan_idx <= scan_idx + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key <= {req.color_red, req.color_green, req.color_blue};
    end
    if (rd_en) begin
      cmp_idx <= scan_idx[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (wr_en) begin
      fill_count <= fill_count + COUNT_W'(1);
    end
  end

  // slot chosen: match position, or the next free slot
  assign slot_sel = status.hit ? cmp_idx : fill_count[SLOT_W-1:0];
  assign col      = slot_sel[SIDE_W-1:0];
  assign row      = slot_sel[SLOT_W-1:SIDE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (!status.hit && full) begin
        rsp.slot_column <= '0;
        rsp.slot_row    <= '0;
        rsp.u_numerator <= '0;
        rsp.v_numerator <= '0;
        rsp.newly_added <= 1'b0;
        rsp.table_full  <= 1'b1;
      end else begin
        rsp.slot_column <= 5'(col);
        rsp.slot_row    <= 5'(row);
        rsp.u_numerator <= 6'({col, 1'b1});
        rsp.v_numerator <= 6'({SIDE_W'(TEXTURE_SIDE - 1) - row, 1'b1});
        rsp.newly_added <= !status.hit;
        rsp.table_full  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/cpsa_checker.sv
// ----------------------------------------------------------------------------
// cpsa_checker
// Port-level checks on the palette slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "color_palette_slot_allocator_core_macros.svh"

module cpsa_checker (
  input wire                clk,
  input wire                rst,
  input wire                req_valid,
  input wire                req_ready,
  input wire                rsp_valid,
  input wire                rsp_ready,
  input cpsa_pkg::cpsa_rsp_t rsp
);
  import cpsa_pkg::*;

  // result held stable until taken
  `CPSA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result dropped or changed while stalled")

  // one request in flight: no back-to-back acceptance
  `CPSA_ASSERT_NEXT(a_one_req, clk, rst, req_valid && req_ready, !req_ready, "request accepted while search running")

  // table full result carries no slot and no texel write
  `CPSA_ASSERT_IMPL(a_full_zero, clk, rst, rsp_valid && rsp.table_full, !rsp.newly_added && rsp.slot_column == '0 && rsp.slot_row == '0 && rsp.u_numerator == '0 && rsp.v_numerator == '0, "table_full result not cleared")

  // any real slot has odd texture coordinate numerators
  `CPSA_ASSERT_IMPL(a_odd_uv, clk, rst, rsp_valid && !rsp.table_full, rsp.u_numerator[0] && rsp.v_numerator[0], "slot coordinates not at texel centre")

endmodule

bind color_palette_slot_allocator_core cpsa_checker u_cpsa_checker (.*);

`default_nettype wire
